/* rtl/itf_pkg.sv */
// shared types, constants and codes for the track id fuser
// no dependencies
`default_nettype none
package itf_pkg;
    localparam int unsigned DefTableDepth = 32;
    localparam int unsigned UsPerMs       = 1000;

    typedef enum logic [1:0] {
        MODE_TRACK    = 2'd0,
        MODE_SWEEP    = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_SNAPSHOT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_CREATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_SNAP     = 3'd3,
        ST_SNAP_NIL = 3'd4,
        ST_DONE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_TTL  = 2'd0,
        CFG_GATE = 2'd1,
        CFG_IOU  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_GEOM,
        S_MUL,
        S_GATE,
        S_CMP,
        S_DECIDE,
        S_SNAP_FIND,
        S_SNAP_EMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  camera;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [47:0] stamp_us;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] object_id;
        logic [7:0]  object_camera;
        logic [15:0] object_left;
        logic [15:0] object_top;
        logic [15:0] object_width;
        logic [15:0] object_height;
        logic [47:0] object_seen_us;
        logic        last;
    } t_out_beat;
endpackage
`default_nettype wire

/* rtl/iou_track_id_fuser_unit.sv */
// track id fuser top level: entry table, sweep/match/snapshot sequencer
// uses itf_pkg
// track: a sweep pass over every entry, then per entry an early exit when free or out of gate,
// else a scoring pass through the shared multiplier, plus a ratio compare against the best
// so far when one exists; sweep/clear: the sweep pass only; snapshot: the sweep pass, then
// a full-table min-id scan before each listed entry's beat
// throughput: one item at a time, not ready until the last result beat is taken
// reset: valid bits cleared, id counter to one, registers to defaults; no clearing pass
`default_nettype none
module iou_track_id_fuser_unit
    import itf_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // table memory fields
    logic [31:0] r_eid  [TABLE_DEPTH];
    logic [7:0]  r_ecam [TABLE_DEPTH];
    logic [63:0] r_ebox [TABLE_DEPTH];
    logic [47:0] r_eseen[TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [TABLE_DEPTH-1:0] r_listed, n_listed;

    logic [15:0] r_ttl, r_tgate;
    logic [16:0] r_iou;
    logic [31:0] r_next_id, n_next_id;

    t_state      r_state, n_state;
    t_in_beat    r_in, n_in;
    t_out_beat   r_out, n_out;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_step, n_step;

    // shared multiplier, registered result
    logic [33:0] r_ma, n_ma, r_mb, n_mb;
    logic [67:0] r_prod;
    logic [67:0] mul_q;

    // per candidate scratch
    logic [31:0] r_inter, n_inter;
    logic [32:0] r_cu, n_cu;
    logic [67:0] r_p1, n_p1;
    logic        r_ok, n_ok;
    logic        r_has_best, n_has_best;
    logic [IW-1:0] r_best, n_best;
    logic [31:0] r_bi, n_bi;
    logic [32:0] r_bu, n_bu;
    logic        r_has_free, n_has_free;
    logic [IW-1:0] r_free, n_free;
    logic [31:0] r_min_id, n_min_id;

    // memory write port
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic        wr_new_id;

    logic [IW-1:0] cur;
    logic [47:0] seen_c, dt, ttl_us, gate_us, ts;
    logic [48:0] exp_lim;
    logic [16:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;
    logic [16:0] iw, ih;
    logic [15:0] ax, ay, aw, ah;
    logic [32:0] uni_c;

    always_comb cur = r_idx[IW-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
    assign o_out_valid = (r_state == S_OUT) || (r_state == S_SNAP_EMIT);
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl   <= 16'd1000;
            r_tgate <= 16'd200;
            r_iou   <= 17'd19661;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TTL:  r_ttl   <= i_cfg_data[15:0];
                CFG_GATE: r_tgate <= i_cfg_data[15:0];
                CFG_IOU:  r_iou   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign mul_q = r_ma * r_mb;

    always_comb begin
        ts      = r_in.stamp_us;
        ttl_us  = 48'(r_ttl) * 48'(UsPerMs);
        gate_us = 48'(r_tgate) * 48'(UsPerMs);
        seen_c  = r_eseen[cur];
        exp_lim = 49'(seen_c) + 49'(ttl_us);
        dt      = (ts > seen_c) ? ts - seen_c : seen_c - ts;
        {ah, aw, ay, ax} = r_ebox[cur];
        ax2 = 17'(ax) + 17'(aw);
        ay2 = 17'(ay) + 17'(ah);
        bx2 = 17'(r_in.box_left) + 17'(r_in.box_width);
        by2 = 17'(r_in.box_top) + 17'(r_in.box_height);
        x1  = (ax > r_in.box_left) ? 17'(ax) : 17'(r_in.box_left);
        y1  = (ay > r_in.box_top) ? 17'(ay) : 17'(r_in.box_top);
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        iw  = (x2 > x1) ? x2 - x1 : '0;
        ih  = (y2 > y1) ? y2 - y1 : '0;
        // union of two full-size boxes needs the 33rd bit
        uni_c = 33'(r_prod[31:0]) + r_cu - 33'(r_inter);
    end

    always_comb begin
        n_state = r_state;  n_in = r_in;  n_out = r_out;
        n_idx = r_idx;  n_step = r_step;
        n_ma = r_ma;  n_mb = r_mb;
        n_inter = r_inter;  n_cu = r_cu;  n_p1 = r_p1;  n_ok = r_ok;
        n_has_best = r_has_best;  n_best = r_best;  n_bi = r_bi;  n_bu = r_bu;
        n_has_free = r_has_free;  n_free = r_free;
        n_valid = r_valid;  n_listed = r_listed;  n_min_id = r_min_id;
        n_next_id = r_next_id;
        wr_en = 1'b0;  wr_addr = r_free;  wr_new_id = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_data;
                    n_idx = '0;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_valid[cur] && 49'(ts) > exp_lim)
                    n_valid[cur] = 1'b0;
                if (r_idx == CW'(TABLE_DEPTH - 1)) begin
                    n_idx = '0;
                    n_has_best = 1'b0;  n_has_free = 1'b0;
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_listed = '0;
                    unique case (t_mode'(r_in.mode))
                        MODE_TRACK: n_state = S_GEOM;
                        MODE_SWEEP: begin
                            n_out.status = ST_DONE;  n_state = S_OUT;
                        end
                        MODE_CLEAR: begin
                            n_valid = '0;
                            n_out.status = ST_DONE;  n_state = S_OUT;
                        end
                        MODE_SNAPSHOT: begin
                            n_has_best = 1'b0;  n_state = S_SNAP_FIND;
                        end
                        default: ;
                    endcase
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // step 0: geometry, multiply overlap area
            S_GEOM: begin
                if (!r_valid[cur]) begin
                    if (!r_has_free) begin
                        n_has_free = 1'b1;  n_free = cur;
                    end
                    n_state = S_DECIDE;
                end else if (dt > gate_us) begin
                    n_state = S_DECIDE;
                end else begin
                    n_ma = 34'(iw);  n_mb = 34'(ih);
                    n_step = 2'd0;
                    n_state = S_MUL;
                end
            end
            // sequence of products through the shared multiplier
            S_MUL: begin
                unique case (r_step)
                    2'd0: begin
                        n_ma = 34'(aw);  n_mb = 34'(ah);
                        n_step = 2'd1;
                    end
                    2'd1: begin
                        n_inter = r_prod[31:0];
                        n_ma = 34'(r_in.box_width);  n_mb = 34'(r_in.box_height);
                        n_step = 2'd2;
                    end
                    2'd2: begin
                        n_cu = 33'(r_prod[31:0]);
                        n_step = 2'd3;
                    end
                    default: begin
                        // r_cu holds area a, r_prod area b
                        n_cu = uni_c;
                        n_ok = (uni_c != '0) && (r_inter != '0);
                        n_ma = 34'(r_iou);  n_mb = 34'(uni_c);
                        n_step = 2'd0;
                        n_state = S_GATE;
                    end
                endcase
            end
            // gate product is in r_prod once r_step is 1 here
            S_GATE: begin
                if (r_step == 2'd0) begin
                    n_step = 2'd1;
                end else begin
                    n_step = 2'd0;
                    n_ma = 34'(r_inter);  n_mb = 34'(r_bu);
                    if (!r_ok || 68'({r_inter, 16'd0}) < r_prod)
                        n_state = S_DECIDE;
                    else if (!r_has_best) begin
                        n_has_best = 1'b1;  n_best = cur;
                        n_bi = r_inter;  n_bu = r_cu;
                        n_state = S_DECIDE;
                    end else
                        n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_step == 2'd0) begin
                    n_ma = 34'(r_bi);  n_mb = 34'(r_cu);
                    n_step = 2'd1;
                end else if (r_step == 2'd1) begin
                    n_p1 = r_prod;
                    n_step = 2'd2;
                end else begin
                    if (r_p1 > r_prod ||
                        (r_p1 == r_prod && r_eid[cur] < r_eid[r_best])) begin
                        n_best = cur;  n_bi = r_inter;  n_bu = r_cu;
                    end
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_idx == CW'(TABLE_DEPTH - 1)) begin
                    if (r_has_best) begin
                        wr_en = 1'b1;  wr_addr = r_best;
                        n_out.status = ST_UPDATED;
                        n_out.object_id = r_eid[r_best];
                    end else if (r_has_free) begin
                        wr_en = 1'b1;  wr_addr = r_free;  wr_new_id = 1'b1;
                        n_valid[r_free] = 1'b1;
                        n_out.status = ST_CREATED;
                        n_out.object_id = r_next_id;
                        n_next_id = (r_next_id == '1) ? 32'd1 : r_next_id + 1'b1;
                    end else begin
                        n_out.status = ST_FULL;
                    end
                    if (r_has_best || r_has_free) begin
                        n_out.object_camera = r_in.camera;
                        n_out.object_left   = r_in.box_left;
                        n_out.object_top    = r_in.box_top;
                        n_out.object_width  = r_in.box_width;
                        n_out.object_height = r_in.box_height;
                        n_out.object_seen_us = r_in.stamp_us;
                    end
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_GEOM;
                end
            end
            // scan for lowest unlisted id, first slot wins ties
            S_SNAP_FIND: begin
                if (r_valid[cur] && !r_listed[cur] &&
                    (!r_has_best || r_eid[cur] < r_min_id)) begin
                    n_has_best = 1'b1;  n_best = cur;  n_min_id = r_eid[cur];
                end
                if (r_idx == CW'(TABLE_DEPTH - 1)) begin
                    n_idx = '0;
                    if (!n_has_best) begin
                        n_out = '0;  n_out.status = ST_SNAP_NIL;  n_out.last = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_listed[n_best] = 1'b1;
                        n_out.status = ST_SNAP;
                        n_out.object_id = r_eid[n_best];
                        n_out.object_camera = r_ecam[n_best];
                        {n_out.object_height, n_out.object_width,
                         n_out.object_top, n_out.object_left} = r_ebox[n_best];
                        n_out.object_seen_us = r_eseen[n_best];
                        n_out.last = ((r_valid & ~r_listed) ==
                                      (TABLE_DEPTH'(1) << n_best));
                        n_state = S_SNAP_EMIT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SNAP_EMIT: begin
                if (i_out_ready) begin
                    n_has_best = 1'b0;
                    n_state = r_out.last ? S_IDLE : S_SNAP_FIND;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_next_id <= 32'd1;
            r_listed  <= '0;
            r_has_best <= 1'b0;
            r_has_free <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_next_id <= n_next_id;
            r_listed  <= n_listed;
            r_has_best <= n_has_best;
            r_has_free <= n_has_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;  r_out <= n_out;  r_idx <= n_idx;  r_step <= n_step;
        r_ma <= n_ma;  r_mb <= n_mb;  r_prod <= mul_q;
        r_inter <= n_inter;  r_cu <= n_cu;  r_p1 <= n_p1;  r_ok <= n_ok;
        r_best <= n_best;  r_bi <= n_bi;  r_bu <= n_bu;  r_free <= n_free;
        r_min_id <= n_min_id;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_new_id) r_eid[wr_addr] <= r_next_id;
            r_ecam[wr_addr]  <= r_in.camera;
            r_ebox[wr_addr]  <= {r_in.box_height, r_in.box_width,
                                 r_in.box_top, r_in.box_left};
            r_eseen[wr_addr] <= r_in.stamp_us;
        end
    end
endmodule
`default_nettype wire

/* rtl/itf_checker.sv */
// port-level checker for the track id fuser, bound to the top level
// uses itf_pkg
`default_nettype none
module itf_checker
    import itf_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out_data,
    input wire logic      o_cfg_ready
);
    // never ready for input while a result beat waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("in ready during output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // an accepted item blocks further input next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("ready after accept");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> o_in_ready) else $error("cfg ready while busy");

    // non-snapshot statuses always close the item
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_SNAP |-> o_out_data.last)
        else $error("single result without last");
endmodule

bind iou_track_id_fuser_unit itf_checker u_itf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

/* dv/iou_track_id_fuser_unit_tb.sv */
// testbench for iou_track_id_fuser_unit: queue-fed driver, clocked monitor, in-line table predictor
// depends on rtl/itf_pkg.sv and rtl/iou_track_id_fuser_unit.sv
`default_nettype none
module iou_track_id_fuser_unit_tb;
    import itf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 32;
    localparam logic [47:0] StampMax = 48'hFFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index = CFG_TTL;
    logic [16:0] cfg_data = '0;

    iou_track_id_fuser_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predicted block state
    logic [15:0] ttl_ms = 16'd1000;
    logic [15:0] gate_ms = 16'd200;
    logic [16:0] iou_min = 17'd19661;
    logic        obj_live [Depth];
    logic [31:0] obj_id [Depth];
    logic [7:0]  obj_cam [Depth];
    logic [15:0] obj_l [Depth], obj_t [Depth], obj_w [Depth], obj_h [Depth];
    logic [47:0] obj_seen [Depth];
    logic [31:0] id_counter = 32'd1;

    t_in_beat  pending_beats [$];
    t_out_beat expected_beats [$];
    int        fail_count = 0;

    // stimulus scene: a few moving boxes so tracks actually associate
    logic [15:0] scene_l [6], scene_t [6], scene_w [6], scene_h [6];
    logic [47:0] clock_us = 48'd1_000_000;

    function automatic t_out_beat obj_beat(t_status st, int slot, logic last);
        t_out_beat b;
        b = '0;
        b.status = st;
        if (slot >= 0) begin
            b.object_id      = obj_id[slot];
            b.object_camera  = obj_cam[slot];
            b.object_left    = obj_l[slot];
            b.object_top     = obj_t[slot];
            b.object_width   = obj_w[slot];
            b.object_height  = obj_h[slot];
            b.object_seen_us = obj_seen[slot];
        end
        b.last = last;
        return b;
    endfunction

    // true when this snapshot listed at least one entry
    function automatic logic snap_listed_any(input logic done [Depth]);
        for (int i = 0; i < Depth; i++) if (done[i]) return 1'b1;
        return 1'b0;
    endfunction

    task automatic fuse_track_item(input t_in_beat b);
        longint unsigned ttl_us, gate_us, dt, inter, uni, best_i, best_u, x1, y1, x2, y2;
        longint unsigned iw, ih;
        logic [127:0] lhs, rhs;
        int best, free_slot, pick;
        logic done [Depth];
        ttl_us = longint'(ttl_ms) * 1000;
        gate_us = longint'(gate_ms) * 1000;
        best = -1; free_slot = -1; best_i = 0; best_u = 1;
        for (int i = 0; i < Depth; i++)
            if (obj_live[i] && longint'(b.stamp_us) > longint'(obj_seen[i]) + ttl_us)
                obj_live[i] = 1'b0;
        case (t_mode'(b.mode))
            MODE_TRACK: begin
                for (int i = 0; i < Depth; i++) begin
                    if (!obj_live[i]) begin
                        if (free_slot < 0) free_slot = i;
                        continue;
                    end
                    dt = (b.stamp_us > obj_seen[i]) ? b.stamp_us - obj_seen[i]
                                                    : obj_seen[i] - b.stamp_us;
                    if (dt > gate_us) continue;
                    x1 = (obj_l[i] > b.box_left) ? obj_l[i] : b.box_left;
                    y1 = (obj_t[i] > b.box_top) ? obj_t[i] : b.box_top;
                    x2 = longint'(obj_l[i]) + obj_w[i];
                    if (longint'(b.box_left) + b.box_width < x2) x2 = longint'(b.box_left) + b.box_width;
                    y2 = longint'(obj_t[i]) + obj_h[i];
                    if (longint'(b.box_top) + b.box_height < y2) y2 = longint'(b.box_top) + b.box_height;
                    iw = (x2 > x1) ? x2 - x1 : 0;
                    ih = (y2 > y1) ? y2 - y1 : 0;
                    inter = iw * ih;
                    uni = longint'(obj_w[i]) * obj_h[i] + longint'(b.box_width) * b.box_height - inter;
                    if (uni == 0 || inter == 0) continue;
                    if (inter * 65536 < longint'(iou_min) * uni) continue;
                    if (best < 0) begin
                        best = i; best_i = inter; best_u = uni;
                        continue;
                    end
                    // exact ratio compare needs more than 64 bits
                    lhs = 128'(inter) * 128'(best_u);
                    rhs = 128'(best_i) * 128'(uni);
                    if (lhs > rhs || (lhs == rhs && obj_id[i] < obj_id[best])) begin
                        best = i; best_i = inter; best_u = uni;
                    end
                end
                if (best < 0 && free_slot < 0) begin
                    expected_beats = {expected_beats, obj_beat(ST_FULL, -1, 1'b1)};
                end else begin
                    if (best < 0) begin
                        best = free_slot;
                        obj_live[best] = 1'b1;
                        obj_id[best] = id_counter;
                        id_counter = id_counter + 1;
                        if (id_counter == 0) id_counter = 32'd1;
                    end
                    obj_cam[best] = b.camera;
                    obj_l[best] = b.box_left;  obj_t[best] = b.box_top;
                    obj_w[best] = b.box_width; obj_h[best] = b.box_height;
                    obj_seen[best] = b.stamp_us;
                    expected_beats = {expected_beats,
                                      obj_beat(free_slot == best && best_i == 0 ?
                                               ST_CREATED : ST_UPDATED, best, 1'b1)};
                end
            end
            MODE_SNAPSHOT: begin
                for (int i = 0; i < Depth; i++) done[i] = 1'b0;
                pick = 0;
                for (int n = 0; n < Depth && pick >= 0; n++) begin
                    pick = -1;
                    for (int i = 0; i < Depth; i++)
                        if (obj_live[i] && !done[i] && (pick < 0 || obj_id[i] < obj_id[pick]))
                            pick = i;
                    if (pick >= 0) begin
                        done[pick] = 1'b1;
                        expected_beats = {expected_beats, obj_beat(ST_SNAP, pick, 1'b0)};
                    end
                end
                if (expected_beats.size() > 0 && expected_beats[$].status == ST_SNAP &&
                    !expected_beats[$].last && snap_listed_any(done))
                    expected_beats[$].last = 1'b1;
                else
                    expected_beats = {expected_beats, obj_beat(ST_SNAP_NIL, -1, 1'b1)};
            end
            default: begin
                if (t_mode'(b.mode) == MODE_CLEAR)
                    for (int i = 0; i < Depth; i++) obj_live[i] = 1'b0;
                expected_beats = {expected_beats, obj_beat(ST_DONE, -1, 1'b1)};
            end
        endcase
    endtask

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) fuse_track_item(in_data);
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // receiver stalls on a cycling pattern: none, light, heavy
    int cycle_no = 0;
    always @(posedge i_clk) begin
        t_out_beat want;
        cycle_no++;
        case ((cycle_no / 97) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected, status %0d", o_out_data.status);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("status", want.status, o_out_data.status);
                check_field("object_id", want.object_id, o_out_data.object_id);
                check_field("object_camera", want.object_camera, o_out_data.object_camera);
                check_field("object_left", want.object_left, o_out_data.object_left);
                check_field("object_top", want.object_top, o_out_data.object_top);
                check_field("object_width", want.object_width, o_out_data.object_width);
                check_field("object_height", want.object_height, o_out_data.object_height);
                check_field("object_seen_us", want.object_seen_us, o_out_data.object_seen_us);
                check_field("last", want.last, o_out_data.last);
            end
        end
    end

    task automatic queue_item(input t_mode m, input logic [7:0] cam, input logic [15:0] l,
                              input logic [15:0] t, input logic [15:0] w, input logic [15:0] h,
                              input logic [47:0] stamp);
        t_in_beat b;
        b.mode = m; b.camera = cam; b.box_left = l; b.box_top = t;
        b.box_width = w; b.box_height = h; b.stamp_us = stamp;
        pending_beats = {pending_beats, b};
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        // every accepted item has had its results taken; wait before the next phase
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TTL:  ttl_ms = value[15:0];
            CFG_GATE: gate_ms = value[15:0];
            default:  iou_min = value;
        endcase
    endtask

    task automatic queue_random(input int count);
        int r, k;
        t_in_beat b;
        logic [127:0] raw;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0 && clock_us > 48'd400_000)
                clock_us = clock_us - $urandom_range(0, 300_000);
            else if ($urandom_range(0, 19) == 0)
                clock_us = clock_us + $urandom_range(1_000_000, 4_000_000);
            else
                clock_us = clock_us + $urandom_range(0, 60_000);
            if (r < 70) begin
                scene_l[k] = 16'(scene_l[k] + $urandom_range(0, 6) - 3);
                scene_t[k] = 16'(scene_t[k] + $urandom_range(0, 6) - 3);
                scene_w[k] = 16'(scene_w[k] + $urandom_range(0, 4) - 2);
                scene_h[k] = 16'(scene_h[k] + $urandom_range(0, 4) - 2);
                queue_item(MODE_TRACK, 8'($urandom), scene_l[k], scene_t[k],
                           scene_w[k], scene_h[k], clock_us);
            end else if (r < 78) begin
                queue_item(MODE_TRACK, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), clock_us);
            end else if (r < 84) begin
                queue_item(MODE_SWEEP, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), clock_us);
            end else if (r < 88) begin
                queue_item(MODE_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), clock_us);
            end else if (r < 96) begin
                queue_item(MODE_SNAPSHOT, 8'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), clock_us);
            end else begin
                // fully random beat, the stamp bits too
                raw = {$urandom, $urandom, $urandom, $urandom};
                b = raw[$bits(t_in_beat)-1:0];
                pending_beats = {pending_beats, b};
                if (b.stamp_us > clock_us) clock_us = b.stamp_us;
                if (clock_us > StampMax - 48'd100_000_000) clock_us = 48'($urandom);
            end
        end
    endtask

    initial begin
        logic [47:0] t0;
        for (int i = 0; i < Depth; i++) obj_live[i] = 1'b0;
        for (int k = 0; k < 6; k++) begin
            scene_l[k] = 16'(k * 300 + 50); scene_t[k] = 16'(k * 120 + 20);
            scene_w[k] = 16'($urandom_range(20, 200)); scene_h[k] = 16'($urandom_range(20, 200));
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with reset settings
        t0 = clock_us;
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0);
        queue_item(MODE_SWEEP, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0);
        queue_item(MODE_TRACK, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0);
        queue_item(MODE_TRACK, 8'd255, 16'd0, 16'd0, 16'd10, 16'd10, t0);
        queue_item(MODE_TRACK, 8'd1, 16'd10, 16'd0, 16'd10, 16'd10, t0);
        // equal overlap with both neighbors, lower id wins
        queue_item(MODE_TRACK, 8'd2, 16'd5, 16'd0, 16'd10, 16'd10, t0 + 1);
        queue_item(MODE_TRACK, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, t0 + 2);
        queue_item(MODE_TRACK, 8'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, t0 + 3);
        // stamp older than the stored one
        queue_item(MODE_TRACK, 8'd5, 16'd1000, 16'd1000, 16'd30, 16'd30, t0 - 500_000);
        queue_item(MODE_TRACK, 8'd6, 16'd1001, 16'd1000, 16'd30, 16'd30, t0 + 4);
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0 + 5);
        queue_item(MODE_SWEEP, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0 + 5_000_000);
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0 + 5_000_001);
        queue_item(MODE_TRACK, 8'd7, 16'd100, 16'd100, 16'd40, 16'd40, t0 + 5_000_002);
        queue_item(MODE_CLEAR, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, t0 + 5_000_003);
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, t0 + 5_000_004);
        queue_item(MODE_TRACK, 8'd8, 16'd100, 16'd100, 16'd40, 16'd40, StampMax);
        queue_item(MODE_SWEEP, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd0);
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd0);
        queue_item(MODE_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd0);
        wait_idle();

        // low extremes: instant expiry, exact time match, any overlap
        write_reg(CFG_TTL, 17'd0);
        write_reg(CFG_GATE, 17'd0);
        write_reg(CFG_IOU, 17'd0);
        clock_us = 48'd2_000_000;
        queue_random(20);
        wait_idle();

        // high extremes: fill the table past its depth
        write_reg(CFG_TTL, 17'd65535);
        write_reg(CFG_GATE, 17'd65535);
        write_reg(CFG_IOU, 17'd65536);
        queue_item(MODE_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, clock_us);
        for (int k = 0; k < 36; k++)
            queue_item(MODE_TRACK, 8'(k), 16'(k * 100), 16'd0, 16'd50, 16'd50,
                       clock_us + 48'(k * 1000));
        queue_item(MODE_SNAPSHOT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, clock_us + 48'd40_000);
        queue_item(MODE_TRACK, 8'd9, 16'd300, 16'd0, 16'd50, 16'd50, clock_us + 48'd41_000);
        queue_item(MODE_CLEAR, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, clock_us + 48'd42_000);
        clock_us = clock_us + 48'd50_000;
        wait_idle();

        for (int ph = 0; ph < 2; ph++) begin
            write_reg(CFG_TTL, 17'($urandom_range(300, 3000)));
            write_reg(CFG_GATE, 17'($urandom_range(50, 500)));
            write_reg(CFG_IOU, 17'($urandom_range(6000, 50000)));
            queue_random(40);
            wait_idle();
        end

        write_reg(CFG_TTL, 17'd1000);
        write_reg(CFG_GATE, 17'd200);
        write_reg(CFG_IOU, 17'd19661);
        queue_random(25);
        wait_idle();

        if (fail_count == 0 && expected_beats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/itf_pkg.sv
rtl/iou_track_id_fuser_unit.sv
rtl/itf_checker.sv
dv/iou_track_id_fuser_unit_tb.sv
